// ----- design/b64td_pkg.sv -----
// Shared types, constants and the character decode function of the base64 decoder.
`timescale 1ns / 1ps

package b64td_pkg;

    localparam int BC_W      = 24;               // byte count width
    localparam int GT_W      = 22;               // group counter width
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [GT_W-1:0] GROUP_MAX = {GT_W{1'b1}};
    localparam logic [BC_W-1:0] MAX_OUT_RESET = {BC_W{1'b1}};
    localparam logic            REG_MAX_OUT_IDX = 1'b0;
    localparam logic [7:0]      CH_PAD = 8'h3D;  // '='

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_GROUP = 2'd1,
        ST_TOO_BIG  = 2'd2
    } status_t;

    // One queued command: optional flushed group, final group bytes, status.
    typedef struct packed {
        logic            a_vld;
        logic [23:0]     grp_a;
        logic [23:0]     grp_b;
        logic [1:0]      b_cnt;
        logic            is_end;
        status_t         status;
        logic [BC_W-1:0] count;
    } q_entry_t;

    // Returns {valid, sextet}.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)               r = {1'b1, 6'd62};
        else if (c == 8'h2F)               r = {1'b1, 6'd63};
        else if (c == CH_PAD)              r = {1'b1, 6'd0};
        return r;
    endfunction

endpackage

// ----- design/b64td_front.sv -----
// Front end: classify characters, assemble groups, queue flush and end commands.
`timescale 1ns / 1ps

module b64td_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_vld,
    input  logic                     in_rdy,
    input  logic [7:0]               char_code,
    input  logic                     is_last,
    input  logic [b64td_pkg::BC_W-1:0] max_out,
    output logic                     push,
    output b64td_pkg::q_entry_t      push_data
);

    logic [17:0]                     buf_reg, buf_next;
    logic [1:0]                      fill_reg, fill_next;
    logic [23:0]                     pend_reg, pend_next;
    logic                            pvld_reg, pvld_next;
    logic [b64td_pkg::GT_W-1:0]      total_reg, total_next;
    logic [b64td_pkg::BC_W-1:0]      triple_reg, triple_next;
    logic [1:0]                      pad_reg, pad_next;

    logic [6:0]                      sx;
    logic                            acc, flush;
    logic [b64td_pkg::BC_W-1:0]      t_len;
    b64td_pkg::status_t              st;

    assign acc = in_vld && in_rdy;
    assign sx  = b64td_pkg::sextet_of(char_code);

    always_comb begin
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        pvld_next   = pvld_reg;
        total_next  = total_reg;
        triple_next = triple_reg;
        pad_next    = pad_reg;
        flush       = 1'b0;
        if (sx[6]) begin
            if (char_code == b64td_pkg::CH_PAD && pad_reg < 2'd2) begin
                pad_next = pad_reg + 2'd1;
            end
            if (fill_reg == 2'd3) begin
                flush     = pvld_reg;
                pend_next = {buf_reg, sx[5:0]};
                pvld_next = 1'b1;
                if (total_reg < b64td_pkg::GROUP_MAX) begin
                    total_next  = total_reg + b64td_pkg::GT_W'(1);
                    triple_next = triple_reg + b64td_pkg::BC_W'(3);
                end
                buf_next  = 18'd0;
                fill_next = 2'd0;
            end else begin
                buf_next  = {buf_reg[11:0], sx[5:0]};
                fill_next = fill_reg + 2'd1;
            end
        end

        // Message length and end status from the updated counters.
        t_len = triple_next - b64td_pkg::BC_W'(pad_next);
        if (!pvld_next) begin
            st = b64td_pkg::ST_NO_GROUP;
        end else if (total_next >= b64td_pkg::GROUP_MAX || t_len > max_out) begin
            st = b64td_pkg::ST_TOO_BIG;
        end else begin
            st = b64td_pkg::ST_OK;
        end

        push_data.grp_a = pend_reg;
        push_data.grp_b = pend_next;
        if (is_last) begin
            push_data.a_vld  = flush && (st == b64td_pkg::ST_OK);
            push_data.b_cnt  = (st == b64td_pkg::ST_OK) ? 2'd3 - pad_next : 2'd0;
            push_data.is_end = 1'b1;
            push_data.status = st;
            push_data.count  = (st == b64td_pkg::ST_OK) ? t_len : '0;
        end else begin
            push_data.a_vld  = 1'b1;
            push_data.b_cnt  = 2'd0;
            push_data.is_end = 1'b0;
            push_data.status = b64td_pkg::ST_OK;
            push_data.count  = '0;
        end
    end

    assign push = acc && (is_last || flush);

    always_ff @(posedge aclk) begin
        if (!aresetn || (acc && is_last)) begin
            buf_reg    <= '0;
            fill_reg   <= '0;
            pend_reg   <= '0;
            pvld_reg   <= 1'b0;
            total_reg  <= '0;
            triple_reg <= '0;
            pad_reg    <= '0;
        end else if (acc) begin
            buf_reg    <= buf_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            pvld_reg   <= pvld_next;
            total_reg  <= total_next;
            triple_reg <= triple_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

// ----- design/b64td_fifo.sv -----
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module b64td_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64td_pkg::q_entry_t  push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_vld,
    output b64td_pkg::q_entry_t  head
);

    b64td_pkg::q_entry_t           mem_reg [b64td_pkg::Q_DEPTH];
    logic [b64td_pkg::Q_AW-1:0]    wr_reg, rd_reg;
    logic [b64td_pkg::Q_AW:0]      cnt_reg;
    logic                          do_push, do_pop;

    assign full     = (cnt_reg == (b64td_pkg::Q_AW+1)'(b64td_pkg::Q_DEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head     = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && head_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + b64td_pkg::Q_AW'(1);
            if (do_pop)  rd_reg <= rd_reg + b64td_pkg::Q_AW'(1);
            cnt_reg <= cnt_reg + (b64td_pkg::Q_AW+1)'(do_push)
                               - (b64td_pkg::Q_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- design/b64td_back.sv -----
// Back end: expand queued commands into data bytes and status items, one per cycle unless stalled.
`timescale 1ns / 1ps

module b64td_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_vld,
    input  b64td_pkg::q_entry_t        head,
    output logic                       pop,
    output logic                       out_vld,
    input  logic                       out_rdy,
    output logic                       out_kind,
    output logic [7:0]                 out_byte,
    output logic [1:0]                 out_status,
    output logic [b64td_pkg::BC_W-1:0] out_count,
    output logic                       out_end
);

    logic                        cur_reg;
    logic [47:0]                 bytes_reg;
    logic [2:0]                  n_reg;
    logic                        end_reg;
    b64td_pkg::status_t          st_reg;
    logic [b64td_pkg::BC_W-1:0]  cnt_reg;

    logic                        ov_reg, kind_reg, oend_reg;
    logic [7:0]                  byte_reg;
    logic [1:0]                  ost_reg;
    logic [b64td_pkg::BC_W-1:0]  ocnt_reg;

    logic out_free, emit, last_of, load;

    assign out_free = !ov_reg || out_rdy;
    assign emit     = cur_reg && out_free;
    assign last_of  = end_reg ? (n_reg == 3'd0) : (n_reg == 3'd1);
    assign load     = !cur_reg || (emit && last_of);
    assign pop      = load && head_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            if (out_free) ov_reg <= emit;
            if (load)     cur_reg <= head_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (n_reg != 3'd0) begin
                kind_reg  <= 1'b0;
                byte_reg  <= bytes_reg[47:40];
                ost_reg   <= b64td_pkg::ST_OK;
                ocnt_reg  <= '0;
                oend_reg  <= 1'b0;
            end else begin
                kind_reg  <= 1'b1;
                byte_reg  <= 8'd0;
                ost_reg   <= st_reg;
                ocnt_reg  <= cnt_reg;
                oend_reg  <= 1'b1;
            end
        end
        // Take the next command, else advance the byte shifter.
        if (load && head_vld) begin
            bytes_reg <= head.a_vld ? {head.grp_a, head.grp_b} : {head.grp_b, 24'd0};
            n_reg     <= head.a_vld ? 3'd3 + {1'b0, head.b_cnt} : {1'b0, head.b_cnt};
            end_reg   <= head.is_end;
            st_reg    <= head.status;
            cnt_reg   <= head.count;
        end else if (emit && n_reg != 3'd0) begin
            bytes_reg <= {bytes_reg[39:0], 8'd0};
            n_reg     <= n_reg - 3'd1;
        end
    end

    assign out_vld    = ov_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_status = ost_reg;
    assign out_count  = ocnt_reg;
    assign out_end    = oend_reg;

endmodule

// ----- design/base64_tolerant_decoder_core.sv -----
// Top level of the tolerant base64 decoder: APB register, front end, queue, back end.
`timescale 1ns / 1ps

// Tolerant base64 decoder.
// Input stream (s_*): one character per transaction in s_tdata, s_tlast on the
// final character of a message. Characters outside the alphabet are skipped;
// '=' decodes as zero and counts as padding (at most two).
// Output stream (m_*): m_tuser = 0 for a decoded data byte, 1 for the status
// transaction that closes the message (m_tlast = 1 on that transaction only).
// Status 0 ok with the decoded length, 1 no complete group, 2 over the limit.
// On an error status any bytes already sent for the message must be dropped.
// Throughput: one character accepted per cycle while the queue has room; the output
// side sends one transaction per cycle while m_tready is high and a command waits;
// it sends 3 bytes per 4 characters in the body, up to 7 transactions at the end.
// Path: a command passes the 4-entry command queue, the sequencer's command register
// and the output register before m_tvalid rises.
// Stall: while m_tready is low the output holds, the queue fills, and
// s_tready drops once the queue is full.
// Reset (aresetn low, synchronous) empties the queue, drops any partial
// message and sets max_output_bytes to its full-scale value.
// Write max_output_bytes over APB at address 0 only while the block is idle.

module base64_tolerant_decoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b64td_pkg::APB_AW-1:0]     paddr,
    input  logic [b64td_pkg::APB_DW-1:0]     pwdata,
    output logic [b64td_pkg::APB_DW-1:0]     prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] char_code
    input  logic                             s_tlast,   // is_last
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,   // [7:0] data_byte, [9:8] status,
                                                        // [33:10] byte_count, rest zero
    output logic                             m_tuser,   // kind
    output logic                             m_tlast    // end_of_run
);

    logic [b64td_pkg::BC_W-1:0]  max_reg;
    logic                        q_full, q_push, q_pop, q_hvld;
    b64td_pkg::q_entry_t         q_in, q_head;
    logic [7:0]                  o_byte;
    logic [1:0]                  o_status;
    logic [b64td_pkg::BC_W-1:0]  o_count;

    // Register write on the access phase; pready is tied high.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= b64td_pkg::MAX_OUT_RESET;
        end else if (psel && penable && pwrite
                     && paddr[2] == b64td_pkg::REG_MAX_OUT_IDX) begin
            max_reg <= pwdata[b64td_pkg::BC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == b64td_pkg::REG_MAX_OUT_IDX)
                  ? b64td_pkg::APB_DW'(max_reg) : '0;

    // Accept a character whenever the queue has room.
    assign s_tready = !q_full;

    b64td_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_vld    (s_tvalid),
        .in_rdy    (s_tready),
        .char_code (s_tdata),
        .is_last   (s_tlast),
        .max_out   (max_reg),
        .push      (q_push),
        .push_data (q_in)
    );

    b64td_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .head_vld  (q_hvld),
        .head      (q_head)
    );

    b64td_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_vld   (q_hvld),
        .head       (q_head),
        .pop        (q_pop),
        .out_vld    (m_tvalid),
        .out_rdy    (m_tready),
        .out_kind   (m_tuser),
        .out_byte   (o_byte),
        .out_status (o_status),
        .out_count  (o_count),
        .out_end    (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {6'd0, o_count, o_status, o_byte};

endmodule

// ----- design/b64td_checker.sv -----
// Port-level checker for the base64 decoder, bound to the top level.
`timescale 1ns / 1ps

module b64td_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Status transactions and only they close a message.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("tlast does not match status kind");

    // Data bytes carry no status and no count.
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[39:8] == 32'd0)
        else $error("data transaction with status fields set");

    // Error status reports zero length and never an unused code.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[9:8] != 2'd0
            |-> m_tdata[33:10] == 24'd0 && m_tdata[9:8] != 2'd3)
        else $error("bad error status transaction");

    // Nothing is offered in the cycle after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base64_tolerant_decoder_core b64td_checker u_b64td_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/base64_tolerant_decoder_core_tb.sv -----
// Self-checking testbench for the tolerant base64 decoder core: directed and random messages.
`timescale 1ns / 1ps

module base64_tolerant_decoder_core_tb;

    import b64td_pkg::*;

    // Register map: max_output_bytes at index 0; index 1 is unmapped and must be ignored.
    localparam logic [APB_AW-1:0] ADDR_MAX_OUT  = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

    // Kind of an output transaction, carried on m_tuser.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int DRAIN_CYCLES  = 10;      // comfortably past the pipeline latency
    localparam int HOLD_CYCLES   = 80;      // long receiver hold-off, fills the queue
    localparam int ITEMS_PER_SET = 12;      // random items per register setting
    localparam int CYCLE_LIMIT   = 100000;
    localparam int MAX_REPORTS   = 40;

    // One expected result transaction, field by field.
    typedef struct packed {
        logic            kind;
        logic [7:0]      data_byte;
        status_t         status;
        logic [BC_W-1:0] byte_count;
        logic            end_of_run;
    } out_item_t;

    // Tracks the decoder state per accepted character and checks every result.
    class decode_scoreboard;
        logic [17:0]     sextets;       // open group, oldest sextet in the top bits
        logic [1:0]      fill;
        logic [23:0]     held_group;    // newest complete group, released by the next group or at the end
        bit              held_valid;
        logic [GT_W-1:0] groups;
        logic [1:0]      pads;
        logic [BC_W-1:0] limit;
        out_item_t       decoded_q[$];
        int              errors, chars, results, messages;
        int              ok_ends, nogroup_ends, toobig_ends;

        function new();
            limit = MAX_OUT_RESET;
            clear_message();
            errors = 0;
            chars = 0;
            results = 0;
            messages = 0;
            ok_ends = 0;
            nogroup_ends = 0;
            toobig_ends = 0;
        endfunction

        function void clear_message();
            sextets = '0;
            fill = '0;
            held_group = '0;
            held_valid = 1'b0;
            groups = '0;
            pads = '0;
        endfunction

        function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
            if (addr == ADDR_MAX_OUT)
                limit = value[BC_W-1:0];
        endfunction

        // Sextet of a character, -1 for anything outside the alphabet and pad.
        function int char_to_sextet(logic [7:0] c);
            if (c >= "A" && c <= "Z") return int'(c) - int'("A");
            if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
            if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
            if (c == "+") return 62;
            if (c == "/") return 63;
            if (c == CH_PAD) return 0;
            return -1;
        endfunction

        function void push_group(logic [23:0] grp, int nbytes);
            out_item_t item;
            for (int k = 0; k < nbytes; k++) begin
                item = '{kind: KIND_DATA, data_byte: grp[23 - 8 * k -: 8], status: ST_OK,
                         byte_count: '0, end_of_run: 1'b0};
                decoded_q.push_back(item);
            end
        endfunction

        function void note_char(logic [7:0] c, bit last);
            int          v;
            bit          flush;
            logic [23:0] flush_group;
            status_t     st;
            longint      total;
            out_item_t   item;
            chars++;
            v = char_to_sextet(c);
            flush = 1'b0;
            flush_group = '0;
            if (v >= 0) begin
                if (c == CH_PAD && pads < 2)
                    pads++;
                if (fill == 2'd3) begin
                    // group complete: the previously held one is released
                    if (held_valid) begin
                        flush = 1'b1;
                        flush_group = held_group;
                    end
                    held_group = {sextets, 6'(v)};
                    held_valid = 1'b1;
                    if (groups != GROUP_MAX)
                        groups++;
                    sextets = '0;
                    fill = '0;
                end else begin
                    sextets = {sextets[11:0], 6'(v)};
                    fill++;
                end
            end
            if (!last) begin
                if (flush)
                    push_group(flush_group, 3);
                return;
            end
            // end of message: any partial group is simply dropped
            messages++;
            total = 0;
            if (groups == 0 || !held_valid) begin
                st = ST_NO_GROUP;
            end else begin
                total = longint'(groups) * 3 - longint'(pads);
                st = (groups == GROUP_MAX || total > longint'(limit)) ? ST_TOO_BIG : ST_OK;
            end
            case (st)
                ST_OK: begin
                    if (flush)
                        push_group(flush_group, 3);
                    push_group(held_group, 3 - int'(pads));
                    ok_ends++;
                end
                ST_NO_GROUP: begin
                    total = 0;
                    nogroup_ends++;
                end
                default: begin
                    total = 0;
                    toobig_ends++;
                end
            endcase
            item = '{kind: KIND_STATUS, data_byte: 8'd0, status: st,
                     byte_count: total[BC_W-1:0], end_of_run: 1'b1};
            decoded_q.push_back(item);
            clear_message();
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH at %0t ns, result %0d: %s", $time, results, what);
        endtask

        task check_result(logic kind, logic [39:0] tdata, logic eor);
            out_item_t want;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected result, tdata %h", tdata));
                return;
            end
            want = decoded_q.pop_front();
            results++;
            if (kind !== want.kind)
                report($sformatf("kind %b, expected %b", kind, want.kind));
            if (tdata[7:0] !== want.data_byte)
                report($sformatf("data_byte %h, expected %h", tdata[7:0], want.data_byte));
            if (tdata[9:8] !== want.status)
                report($sformatf("status %0d, expected %0d", tdata[9:8], want.status));
            if (tdata[10 +: BC_W] !== want.byte_count)
                report($sformatf("byte_count %0d, expected %0d", tdata[10 +: BC_W],
                                 want.byte_count));
            if (tdata[39:10 + BC_W] !== '0)
                report($sformatf("fill bits of tdata not zero: %h", tdata));
            if (eor !== want.end_of_run)
                report($sformatf("end_of_run %b, expected %b", eor, want.end_of_run));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;    // [7:0] char_code
    logic                s_tlast;    // is_last
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;    // [7:0] data_byte, [9:8] status, [33:10] byte_count
    logic                m_tuser;    // kind
    logic                m_tlast;    // end_of_run

    decode_scoreboard    sb;
    logic [7:0]          msg_q[$];   // characters of the message being built
    bit                  burst_mode;      // both sides run without gaps
    bit                  long_hold_req;   // ask the receiver for one long hold-off
    int                  phase_items;
    int                  cycle_count;

    base64_tolerant_decoder_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 2 ns period
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, sb.decoded_q.size());
        $display("Some tests failed");
        $finish;
    end

    // Receiver: check every accepted result, then draw a random stall before the
    // next one. A long hold-off request overrides the drawn stall.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata, m_tlast);
                stall_left = burst_mode ? 0 : $urandom_range(0, 4);
            end
            if (long_hold_req) begin
                stall_left = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one character after a random gap; hold it until the transaction completes.
    // Leave s_tvalid high so a back-to-back character needs no second assignment.
    task automatic send_char(input logic [7:0] code, input bit last);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(code, last);
    endtask

    task automatic send_text(input string text, input bit last);
        for (int i = 0; i < text.len(); i++)
            send_char(text.getc(i), last && (i == text.len() - 1));
    endtask

    // Send the built message; only characters the block acts on count as items.
    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++) begin
            send_char(msg_q[i], i == msg_q.size() - 1);
            if (sb.char_to_sextet(msg_q[i]) >= 0 || i == msg_q.size() - 1)
                phase_items++;
        end
    endtask

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 26) return "A" + 8'(v);
        if (v < 52) return "a" + 8'(v - 26);
        if (v < 62) return "0" + 8'(v - 52);
        return (v == 62) ? "+" : "/";
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (sb.char_to_sextet(r) >= 0);
        return r;
    endfunction

    // Append a character, now and then preceded by a skipped one.
    function automatic void add_char(input logic [7:0] c, input bit noisy);
        if (noisy && $urandom_range(0, 9) == 0)
            msg_q.push_back(noise_char());
        msg_q.push_back(c);
    endfunction

    // Build a message: mostly proper encodings of random payloads, the rest
    // loose runs of alphabet characters with stray pads, or mostly noise.
    // A forced length gives a clean encoding of that many payload bytes.
    task automatic build_message(input int forced_len);
        int          mode, n, len, rem;
        bit          noisy;
        logic [23:0] grp;
        msg_q.delete();
        mode  = (forced_len > 0) ? 0 : $urandom_range(0, 9);
        noisy = (forced_len == 0);
        if (mode < 6) begin
            n = (forced_len > 0) ? forced_len : $urandom_range(1, 15);
            for (int i = 0; i < n; i += 3) begin
                rem = n - i;
                grp = {8'($urandom), (rem > 1) ? 8'($urandom) : 8'd0,
                       (rem > 2) ? 8'($urandom) : 8'd0};
                add_char(alphabet_char(grp[23:18]), noisy);
                add_char(alphabet_char(grp[17:12]), noisy);
                add_char((rem > 1) ? alphabet_char(grp[11:6]) : CH_PAD, noisy);
                add_char((rem > 2) ? alphabet_char(grp[5:0]) : CH_PAD, noisy);
            end
            if (noisy && $urandom_range(0, 4) == 0)
                msg_q.push_back(noise_char());
        end else if (mode < 9) begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++)
                add_char(($urandom_range(0, 7) == 0) ? CH_PAD
                         : alphabet_char(6'($urandom_range(0, 63))), 1'b1);
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                msg_q.push_back(($urandom_range(0, 3) == 0)
                                ? alphabet_char(6'($urandom_range(0, 63))) : noise_char());
        end
    endtask

    // Two-phase register write; the register takes the value at the access edge.
    // Leave the port idle for one cycle afterwards.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, value);
        @(posedge aclk);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.decoded_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        sb            = new();
        burst_mode    = 1'b0;
        long_hold_req = 1'b0;
        phase_items   = 0;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings in turn: reset value, zero, a small limit that splits messages
        // between ok and over-limit, a random limit, and full scale written back.
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                // Directed: two groups with a flush (longest burst at the end),
                // skipped codes at both ends of the range, double pad, a dropped
                // partial group holding only a pad, too few characters, a lone skipped
                // character as the last one, and a pad inside a group.
                send_text("TWFuTWFu", 1'b1);
                send_char(8'h00, 1'b0);
                send_char(8'hFF, 1'b0);
                send_char("T", 1'b0);
                send_char(8'h80, 1'b0);
                send_text("Q==", 1'b1);
                send_text("/+9z=", 1'b1);
                send_text("A", 1'b1);
                send_char(8'h7F, 1'b1);
                send_text("AB=C", 1'b1);
            end else begin
                drain();
                case (phase)
                    1: begin
                        apb_write(ADDR_MAX_OUT, 32'd0);
                        apb_write(ADDR_UNMAPPED, $urandom);
                    end
                    2: apb_write(ADDR_MAX_OUT, {8'($urandom), 24'($urandom_range(3, 20))});
                    3: apb_write(ADDR_MAX_OUT, $urandom);
                    default: apb_write(ADDR_MAX_OUT, {8'($urandom), 24'hFF_FFFF});
                endcase
            end
            phase_items = 0;
            if (phase == 2) begin
                // Hold the receiver off while a long message streams in, so the
                // command queue fills and the input side must stall.
                burst_mode    = 1'b1;
                long_hold_req = 1'b1;
                build_message(24);
                send_message();
            end
            while (phase_items < ITEMS_PER_SET) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                build_message(0);
                send_message();
            end
        end
        drain();

        $display("Decoded %0d messages from %0d characters over five limit settings,",
                 sb.messages, sb.chars);
        $display("checking %0d results: %0d ok, %0d without a group, %0d over the limit.",
                 sb.results, sb.ok_ends, sb.nogroup_ends, sb.toobig_ends);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
